@@ design/aalr_pkg.sv @@
// ----------------------------------------------------------------------------
// aalr_pkg
// Shared types and constants of the antialiased line rasterizer: payload
// structs, command codes, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package aalr_pkg;

   localparam int COORD_BITS    = 12;
   localparam int IMAX_BITS     = 8;
   localparam int FRAC_BITS_DEF = 8;

   localparam logic [IMAX_BITS-1:0] IMAX_RESET = 8'd255;

   // item command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef struct packed {
      logic                  cmd;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [IMAX_BITS-1:0]  intensity;
      logic                  last_pixel;
      logic                  reached_end;
   } rsp_type;

   typedef enum logic [1:0] {
      DIR_HOLD,
      DIR_INC,
      DIR_DEC
   } dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DSTART,
      ST_DIV,
      ST_LINE
   } ctrl_state_type;

   typedef struct packed {
      logic load;        // latch endpoints, deltas and initial error
      logic mul;         // register imax * minor delta
      logic div_go;      // launch the slope division
      logic slope_load;  // take the quotient as slope
      logic step;        // emit one pixel and advance
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;    // quotient valid this cycle
      logic last;        // next pixel is the final one
   } dp_status_type;

endpackage

`default_nettype wire

@@ design/antialiased_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Bresenham-style line walker with coverage intensity per pixel.
// ----------------------------------------------------------------------------
// A start item (cmd 0) loads two endpoints and produces no result; the block
// then computes the slope imax*minor/major delta with a bit-serial divider,
// one quotient bit per cycle, and stalls the input through the product,
// division launch and divide states. Each step item (cmd 1) after that
// yields one pixel item; the last of max(dx,dy)+1 pixels carries last_pixel,
// full imax intensity, and reached_end when it lies on the end point. A step
// item while no line is active is consumed without a result, and a start
// item abandons any active line.
// Results sit in an output register, so a step is accepted while the previous
// pixel waits as long as that pixel is taken in the same cycle. The imax
// register is written through the csr port, which is always ready; write it
// only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module antialiased_line_rasterizer
   import aalr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // imax register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IMAX_BITS-1:0] csr_data
);

   logic [IMAX_BITS-1:0] imax_ff;
   dp_cmd_type           cmd;
   dp_status_type        status;

   // imax register: written whenever the csr item arrives
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         imax_ff <= IMAX_RESET;
      end else if (csr_valid && csr_ready) begin
         imax_ff <= csr_data;
      end
   end

   // sequencing of setup and pixel steps
   aalr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // deltas, slope division, error walk and result register
   aalr_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .imax     (imax_ff),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

@@ design/aalr_div.sv @@
// ----------------------------------------------------------------------------
// aalr_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits QUO_BITS, so the top DIV_BITS numerator bits seed the
// remainder directly.
// ----------------------------------------------------------------------------
`default_nettype none

module aalr_div #(
   parameter int DIV_BITS = 12,
   parameter int QUO_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DIV_BITS+QUO_BITS-1:0] numer,
   input  logic [DIV_BITS-1:0]          divisor,
   output logic [QUO_BITS-1:0]          quotient,
   output logic                         done
);

   localparam int CNT_BITS = $clog2(QUO_BITS + 1);

   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0] sh_ff, sh_in;
   logic                done_ff, done_in;
   logic [DIV_BITS:0]   trial;
   logic [DIV_BITS:0]   diff;
   logic                fits;

   assign trial = {rem_ff, sh_ff[QUO_BITS-1]};
   assign fits  = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_BITS'(QUO_BITS);
         rem_in = numer[DIV_BITS+QUO_BITS-1:QUO_BITS];
         sh_in  = numer[QUO_BITS-1:0];
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         rem_in  = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
         sh_in   = {sh_ff[QUO_BITS-2:0], fits};
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
   end

   assign quotient = sh_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

@@ design/aalr_dpath.sv @@
// ----------------------------------------------------------------------------
// aalr_dpath
// Line datapath: delta setup, slope product and division, error
// accumulator, position stepping and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module aalr_dpath
   import aalr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  req_type              req_data,
   input  logic [IMAX_BITS-1:0] imax,
   output rsp_type              rsp_data
);

   localparam int CW  = COORD_BITS;
   localparam int QW  = IMAX_BITS + FRAC_BITS;      // slope width
   localparam int EW  = QW + 1;                     // error width
   localparam int PW  = IMAX_BITS + CW;             // product width
   localparam int LW  = EW - FRAC_BITS;             // integer part of error

   function automatic logic [CW-1:0] move_coord(input logic [CW-1:0] c, input dir_type d);
      logic [CW-1:0] r;
      case (d)
         DIR_INC: r = c + 1'b1;
         DIR_DEC: r = c - 1'b1;
         default: r = c;
      endcase
      return r;
   endfunction

   // line state
   logic [CW-1:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CW-1:0]        goal_x_ff, goal_y_ff;
   logic [EW-1:0]        err_ff, err_in;
   logic [QW-1:0]        slope_ff, back_ff;
   logic [CW:0]          left_ff, left_in;
   dir_type              dir_x_ff, dir_y_ff;
   logic                 steep_ff;
   logic [CW-1:0]        dmaj_ff, dmin_ff;
   logic [IMAX_BITS-1:0] imax_lat_ff;
   logic [PW-1:0]        prod_ff;
   rsp_type              rsp_ff, rsp_in;

   // setup logic
   logic [CW-1:0]        dx, dy;
   logic                 steep;
   dir_type              dir_x, dir_y;
   logic [QW-1:0]        quot, slope_new, full;
   logic                 div_done;

   // step logic
   logic [LW-1:0]        level;
   logic                 minor_step;
   logic                 last;

   always_comb begin
      dx    = (req_data.x_end >= req_data.x_start) ? req_data.x_end - req_data.x_start
                                                   : req_data.x_start - req_data.x_end;
      dy    = (req_data.y_end >= req_data.y_start) ? req_data.y_end - req_data.y_start
                                                   : req_data.y_start - req_data.y_end;
      steep = dy > dx;
      if (req_data.x_end > req_data.x_start)      dir_x = DIR_INC;
      else if (req_data.x_end < req_data.x_start) dir_x = DIR_DEC;
      else                                        dir_x = DIR_HOLD;
      if (req_data.y_end > req_data.y_start)      dir_y = DIR_INC;
      else if (req_data.y_end < req_data.y_start) dir_y = DIR_DEC;
      else                                        dir_y = DIR_HOLD;
   end

   aalr_div #(
      .DIV_BITS (CW),
      .QUO_BITS (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .numer    ({prod_ff, {FRAC_BITS{1'b0}}}),
      .divisor  (dmaj_ff),
      .quotient (quot),
      .done     (div_done)
   );

   assign full      = {imax_lat_ff, {FRAC_BITS{1'b0}}};
   assign slope_new = (dmaj_ff == '0) ? '0 : quot;
   assign last      = (left_ff[CW:1] == '0);

   always_comb begin
      level      = err_ff[EW-1:FRAC_BITS];
      minor_step = err_ff > {1'b0, back_ff};
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      err_in     = err_ff;
      left_in    = left_ff;
      rsp_in     = rsp_ff;
      if (cmd.load) begin
         cur_x_in = req_data.x_start;
         cur_y_in = req_data.y_start;
         err_in   = EW'({imax, {(FRAC_BITS-1){1'b0}}});
         left_in  = {1'b0, (steep ? dy : dx)} + 1'b1;
      end else if (cmd.step) begin
         rsp_in.pixel_x = cur_x_ff;
         rsp_in.pixel_y = cur_y_ff;
         if (last) begin
            rsp_in.intensity   = imax;
            rsp_in.last_pixel  = 1'b1;
            rsp_in.reached_end = (cur_x_ff == goal_x_ff) && (cur_y_ff == goal_y_ff);
            left_in            = '0;
         end else begin
            rsp_in.intensity   = (level > LW'(imax)) ? imax : level[IMAX_BITS-1:0];
            rsp_in.last_pixel  = 1'b0;
            rsp_in.reached_end = 1'b0;
            left_in            = left_ff - 1'b1;
            // minor axis first, then the major axis always advances
            if (minor_step) begin
               err_in = err_ff - {1'b0, back_ff};
               if (steep_ff) cur_x_in = move_coord(cur_x_ff, dir_x_ff);
               else          cur_y_in = move_coord(cur_y_ff, dir_y_ff);
            end else begin
               err_in = err_ff + {1'b0, slope_ff};
            end
            if (steep_ff) cur_y_in = move_coord(cur_y_in, dir_y_ff);
            else          cur_x_in = move_coord(cur_x_in, dir_x_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      err_ff   <= err_in;
      left_ff  <= left_in;
      rsp_ff   <= rsp_in;
      if (cmd.load) begin
         goal_x_ff   <= req_data.x_end;
         goal_y_ff   <= req_data.y_end;
         dir_x_ff    <= dir_x;
         dir_y_ff    <= dir_y;
         steep_ff    <= steep;
         dmaj_ff     <= steep ? dy : dx;
         dmin_ff     <= steep ? dx : dy;
         imax_lat_ff <= imax;
      end
      if (cmd.mul) begin
         prod_ff <= PW'(imax_lat_ff) * PW'(dmin_ff);
      end
      if (cmd.slope_load) begin
         slope_ff <= slope_new;
         back_ff  <= full - slope_new;
      end
   end

   assign status.div_done = div_done;
   assign status.last     = last;
   assign rsp_data        = rsp_ff;

endmodule

`default_nettype wire

@@ design/aalr_ctrl.sv @@
// ----------------------------------------------------------------------------
// aalr_ctrl
// Controller: sequences line setup (product, division) and pixel steps,
// and owns the input stall and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module aalr_ctrl
   import aalr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           calc;
   logic           take;

   assign calc      = (state_ff == ST_MUL) || (state_ff == ST_DSTART) || (state_ff == ST_DIV);
   assign req_stall = calc || (rsp_valid_ff && rsp_stall);
   assign take      = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && req_cmd == CMD_START) state_in = ST_MUL;
         end
         ST_MUL:    state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_done) state_in = ST_LINE;
         end
         ST_LINE: begin
            if (take && req_cmd == CMD_START)                    state_in = ST_MUL;
            else if (take && req_cmd == CMD_STEP && status.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.load       = take && (req_cmd == CMD_START);
      cmd.mul        = (state_ff == ST_MUL);
      cmd.div_go     = (state_ff == ST_DSTART);
      cmd.slope_load = (state_ff == ST_DIV) && status.div_done;
      cmd.step       = take && (req_cmd == CMD_STEP) && (state_ff == ST_LINE);
      rsp_valid_in   = cmd.step || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_dstart_to_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DSTART |=> state_ff == ST_DIV)
      else $error("division launch not followed by divide state");

   a_step_gives_item: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> rsp_valid_ff)
      else $error("pixel step produced no result item");

   a_line_stays: assert property (@(posedge clock) disable iff (reset)
      cmd.step && !status.last |=> state_ff == ST_LINE)
      else $error("line dropped before its final pixel");

endmodule

`default_nettype wire
